### rtl/djsp_pkg.sv
// Shared types and constants for the deadline job scheduler.
package djsp_pkg;

  localparam int DL_W    = 7;
  localparam int SC_W    = 16;
  localparam int PEN_W   = 23;
  localparam int JOB_W   = DL_W + SC_W;

  localparam logic [PEN_W-1:0] PEN_MAX = {PEN_W{1'b1}};

  typedef struct packed {
    logic [DL_W-1:0] deadline;
    logic [SC_W-1:0] score;
    logic            last;
  } djsp_in_t;

  typedef struct packed {
    logic [PEN_W-1:0] penalty;
    logic             overflow;
  } djsp_out_t;

  typedef enum logic [2:0] {
    S_LOAD,
    S_CLEAR,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_PICK,
    S_PROBE_RD,
    S_PROBE_CHK,
    S_DONE
  } djsp_state_t;

endpackage

### rtl/djsp_ram.sv
// Generic simple dual-port RAM with registered read data.
module djsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/deadline_job_scheduler_penalty_core.sv
// Top level: job store, selection scan and slot search for the deadline scheduler.
//
//   channel | direction | payload     | handshake
//   in_     | input     | djsp_in_t   | in_valid / in_stall
//   out_    | output    | djsp_out_t  | out_valid / out_stall
//
// Jobs load at one transfer per cycle into the job RAM until the last item. A batch
// of n jobs then clears the NUM_SLOTS slot RAM entries, runs n+1 selection passes
// (read and compare per job, then pick), reads and checks each probed slot and posts
// the result. The single job RAM read port sets the scan pace. in_stall is high from
// the last transfer until the result is in the output register, which waits out
// out_stall. Reset (rst_n low, synchronous) empties the batch and output register.
module deadline_job_scheduler_penalty_core #(
  parameter int MAX_JOBS  = 128,
  parameter int NUM_SLOTS = 128
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  djsp_pkg::djsp_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output djsp_pkg::djsp_out_t out_data
);
  import djsp_pkg::*;

  localparam int JI_W = $clog2(MAX_JOBS);
  localparam int JC_W = $clog2(MAX_JOBS + 1);
  localparam int SA_W = $clog2(NUM_SLOTS);

  djsp_state_t state_r, state_nxt;

  logic [JC_W-1:0]  count_r, count_nxt;
  logic             dropped_r, dropped_nxt;
  logic [JC_W-1:0]  scan_idx_r, scan_idx_nxt;
  logic [SA_W-1:0]  clr_idx_r, clr_idx_nxt;
  logic             have_prev_r, have_prev_nxt;
  logic [SC_W-1:0]  prev_sc_r, prev_sc_nxt;
  logic [JI_W-1:0]  prev_idx_r, prev_idx_nxt;
  logic             have_best_r, have_best_nxt;
  logic [SC_W-1:0]  best_sc_r, best_sc_nxt;
  logic [JI_W-1:0]  best_idx_r, best_idx_nxt;
  logic [DL_W-1:0]  best_dl_r, best_dl_nxt;
  logic [SA_W-1:0]  slot_d_r, slot_d_nxt;
  logic [PEN_W-1:0] pen_r, pen_nxt;
  logic             out_valid_r, out_valid_nxt;
  djsp_out_t        out_data_r, out_data_nxt;

  logic             job_we;
  logic [JI_W-1:0]  job_waddr;
  logic [JOB_W-1:0] job_wdata;
  logic [JI_W-1:0]  job_raddr;
  logic [JOB_W-1:0] job_rdata;

  logic             slot_we;
  logic [SA_W-1:0]  slot_waddr;
  logic [0:0]       slot_wdata;
  logic [SA_W-1:0]  slot_raddr;
  logic [0:0]       slot_rdata;

  logic             in_xfer;
  logic [DL_W-1:0]  cur_dl;
  logic [SC_W-1:0]  cur_sc;
  logic [JI_W-1:0]  cur_idx;
  logic             after_prev;
  logic             better;
  logic             scan_end;
  logic [SA_W-1:0]  sat_dl;
  logic [PEN_W:0]   pen_sum;
  logic [PEN_W-1:0] pen_add;

  djsp_ram #(.WIDTH(JOB_W), .DEPTH(MAX_JOBS)) u_job_ram (
    .clk   (clk),
    .we    (job_we),
    .waddr (job_waddr),
    .wdata (job_wdata),
    .raddr (job_raddr),
    .rdata (job_rdata)
  );

  djsp_ram #(.WIDTH(1), .DEPTH(NUM_SLOTS)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  assign in_stall  = (state_r != S_LOAD);
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Selection order is score descending, then index ascending. The next job
  // is the best one that comes strictly after the previously chosen job.
  assign cur_dl     = job_rdata[JOB_W-1:SC_W];
  assign cur_sc     = job_rdata[SC_W-1:0];
  assign cur_idx    = scan_idx_r[JI_W-1:0];
  assign after_prev = !have_prev_r || (cur_sc < prev_sc_r) ||
                      ((cur_sc == prev_sc_r) && (cur_idx > prev_idx_r));
  assign better     = !have_best_r || (cur_sc > best_sc_r);
  assign scan_end   = ((scan_idx_r + JC_W'(1)) == count_r);

  always_comb begin
    if (int'(best_dl_r) > NUM_SLOTS - 1) begin
      sat_dl = SA_W'(NUM_SLOTS - 1);
    end else begin
      sat_dl = SA_W'(best_dl_r);
    end
  end

  assign pen_sum = {1'b0, pen_r} + (PEN_W+1)'(best_sc_r);
  assign pen_add = pen_sum[PEN_W] ? PEN_MAX : pen_sum[PEN_W-1:0];

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_LOAD: begin
        if (in_xfer && in_data.last) begin
          state_nxt = S_CLEAR;
        end
      end
      S_CLEAR: begin
        if (int'(clr_idx_r) == NUM_SLOTS - 1) begin
          state_nxt = S_SCAN_RD;
        end
      end
      S_SCAN_RD:  state_nxt = S_SCAN_CMP;
      S_SCAN_CMP: state_nxt = scan_end ? S_PICK : S_SCAN_RD;
      S_PICK: begin
        if (!have_best_r) begin
          state_nxt = S_DONE;
        end else if (sat_dl == '0) begin
          state_nxt = S_SCAN_RD;
        end else begin
          state_nxt = S_PROBE_RD;
        end
      end
      S_PROBE_RD: state_nxt = S_PROBE_CHK;
      S_PROBE_CHK: begin
        if (slot_rdata == 1'b0 || slot_d_r == SA_W'(1)) begin
          state_nxt = S_SCAN_RD;
        end else begin
          state_nxt = S_PROBE_RD;
        end
      end
      S_DONE: begin
        if (!(out_valid_r && out_stall)) begin
          state_nxt = S_LOAD;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  // Memory controls.
  always_comb begin
    job_we     = (state_r == S_LOAD) && in_xfer && (int'(count_r) < MAX_JOBS);
    job_waddr  = count_r[JI_W-1:0];
    job_wdata  = {in_data.deadline, in_data.score};
    job_raddr  = scan_idx_r[JI_W-1:0];
    slot_we    = 1'b0;
    slot_waddr = slot_d_r;
    slot_wdata = 1'b0;
    slot_raddr = slot_d_r;
    unique case (state_r)
      S_CLEAR: begin
        slot_we    = 1'b1;
        slot_waddr = clr_idx_r;
      end
      S_PROBE_CHK: begin
        slot_we    = (slot_rdata == 1'b0);
        slot_wdata = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Datapath.
  always_comb begin
    count_nxt     = count_r;
    dropped_nxt   = dropped_r;
    scan_idx_nxt  = scan_idx_r;
    clr_idx_nxt   = clr_idx_r;
    have_prev_nxt = have_prev_r;
    prev_sc_nxt   = prev_sc_r;
    prev_idx_nxt  = prev_idx_r;
    have_best_nxt = have_best_r;
    best_sc_nxt   = best_sc_r;
    best_idx_nxt  = best_idx_r;
    best_dl_nxt   = best_dl_r;
    slot_d_nxt    = slot_d_r;
    pen_nxt       = pen_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      S_LOAD: begin
        if (in_xfer) begin
          if (int'(count_r) < MAX_JOBS) begin
            count_nxt = count_r + JC_W'(1);
          end else begin
            dropped_nxt = 1'b1;
          end
          if (in_data.last) begin
            clr_idx_nxt   = '0;
            scan_idx_nxt  = '0;
            have_prev_nxt = 1'b0;
            have_best_nxt = 1'b0;
            pen_nxt       = '0;
          end
        end
      end
      S_CLEAR: begin
        clr_idx_nxt = clr_idx_r + SA_W'(1);
      end
      S_SCAN_RD: begin
      end
      S_SCAN_CMP: begin
        if (after_prev && better) begin
          have_best_nxt = 1'b1;
          best_sc_nxt   = cur_sc;
          best_idx_nxt  = cur_idx;
          best_dl_nxt   = cur_dl;
        end
        scan_idx_nxt = scan_idx_r + JC_W'(1);
      end
      S_PICK: begin
        if (have_best_r) begin
          have_prev_nxt = 1'b1;
          prev_sc_nxt   = best_sc_r;
          prev_idx_nxt  = best_idx_r;
          slot_d_nxt    = sat_dl;
          if (sat_dl == '0) begin
            pen_nxt       = pen_add;
            scan_idx_nxt  = '0;
            have_best_nxt = 1'b0;
          end
        end
      end
      S_PROBE_RD: begin
      end
      S_PROBE_CHK: begin
        if (slot_rdata == 1'b0) begin
          scan_idx_nxt  = '0;
          have_best_nxt = 1'b0;
        end else if (slot_d_r == SA_W'(1)) begin
          pen_nxt       = pen_add;
          scan_idx_nxt  = '0;
          have_best_nxt = 1'b0;
        end else begin
          slot_d_nxt = slot_d_r - SA_W'(1);
        end
      end
      S_DONE: begin
        if (!(out_valid_r && out_stall)) begin
          out_valid_nxt         = 1'b1;
          out_data_nxt.penalty  = pen_r;
          out_data_nxt.overflow = dropped_r;
          count_nxt             = '0;
          dropped_nxt           = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      count_r     <= '0;
      dropped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      dropped_r   <= dropped_nxt;
      out_valid_r <= out_valid_nxt;
    end
    scan_idx_r  <= scan_idx_nxt;
    clr_idx_r   <= clr_idx_nxt;
    have_prev_r <= have_prev_nxt;
    prev_sc_r   <= prev_sc_nxt;
    prev_idx_r  <= prev_idx_nxt;
    have_best_r <= have_best_nxt;
    best_sc_r   <= best_sc_nxt;
    best_idx_r  <= best_idx_nxt;
    best_dl_r   <= best_dl_nxt;
    slot_d_r    <= slot_d_nxt;
    pen_r       <= pen_nxt;
    out_data_r  <= out_data_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(count_r) <= MAX_JOBS)
    else $error("job count exceeds store depth");

  a_probe_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PROBE_RD || state_r == S_PROBE_CHK) |-> (slot_d_r != '0))
    else $error("slot search reached slot zero");

  a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !(out_valid_r && out_stall)) |=>
      (out_valid_r && state_r == S_LOAD && count_r == '0))
    else $error("finished batch did not produce a result");

endmodule
